### rtl/core/ascii_decimal_to_fixed_point_assert.svh
// Assertion macros for the ASCII decimal to fixed-point converter.
// Included by the top level; needs nothing else. Bodies are empty under SYNTHESIS.
`ifndef ASCII_DECIMAL_TO_FIXED_POINT_ASSERT_SVH
`define ASCII_DECIMAL_TO_FIXED_POINT_ASSERT_SVH

`ifndef SYNTHESIS
// Whenever the antecedent holds, the consequent holds in the same cycle.
`define ADFP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");
// The expression never holds at a clock edge outside reset.
`define ADFP_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
    else $error("assertion failed");
`else
`define ADFP_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ADFP_ASSERT_NEVER(label, clk, rst_n, expr)
`endif

`endif

### rtl/core/adfp_pkg.sv
// Shared types, character codes and the power-of-ten tables for the converter.
// Used by the parser, the fraction scaler and the top level; depends on nothing.
`timescale 1ns / 1ps

package adfp_pkg;

  // ASCII codes that steer the parser.
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_POINT = 8'h2E;

  // Nine fraction digits stay below 10^9, which fits in 30 bits.
  localparam int FRAC_ACC_W = 30;
  localparam int DIG_CNT_W  = 4;

  // Parser phase, one-hot.
  typedef enum logic [2:0] {
    PH_START = 3'b001,
    PH_INT   = 3'b010,
    PH_FRAC  = 3'b100
  } adfp_phase_e;

  // Sign and saturation travel together with each number.
  typedef struct packed {
    logic neg;
    logic sat;
  } adfp_flags_t;

  // Divisor for a given count of fraction digits.
  function automatic logic [FRAC_ACC_W-1:0] adfp_pow10(input logic [DIG_CNT_W-1:0] n);
    logic [FRAC_ACC_W-1:0] p;
    case (n)
      4'd0:    p = 30'd1;
      4'd1:    p = 30'd10;
      4'd2:    p = 30'd100;
      4'd3:    p = 30'd1000;
      4'd4:    p = 30'd10000;
      4'd5:    p = 30'd100000;
      4'd6:    p = 30'd1000000;
      4'd7:    p = 30'd10000000;
      4'd8:    p = 30'd100000000;
      4'd9:    p = 30'd1000000000;
      default: p = 30'd1000000000;
    endcase
    return p;
  endfunction

  // Smallest k with 2^k not below the divisor for a given digit count.
  function automatic logic [4:0] adfp_pow10_shift(input logic [DIG_CNT_W-1:0] n);
    logic [4:0] k;
    case (n)
      4'd0:    k = 5'd0;
      4'd1:    k = 5'd4;
      4'd2:    k = 5'd7;
      4'd3:    k = 5'd10;
      4'd4:    k = 5'd14;
      4'd5:    k = 5'd17;
      4'd6:    k = 5'd20;
      4'd7:    k = 5'd24;
      4'd8:    k = 5'd27;
      4'd9:    k = 5'd30;
      default: k = 5'd30;
    endcase
    return k;
  endfunction

endpackage

### rtl/core/adfp_parser.sv
// Character parser: tracks sign, integer and fraction digits and hands a
// finished number to the fraction divider. Depends on adfp_pkg.
`timescale 1ns / 1ps

module adfp_parser #(
  parameter int INT_BITS        = 31,
  parameter int MAX_FRAC_DIGITS = 9
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            char_valid_i,
  input  logic [7:0]                      char_i,
  output logic                            char_ready_o,
  input  logic                            job_ready_i,
  output logic                            job_valid_o,
  output logic [INT_BITS-1:0]             job_int_o,
  output adfp_pkg::adfp_flags_t           job_flags_o,
  output logic [adfp_pkg::FRAC_ACC_W-1:0] job_rem_o,
  output logic [adfp_pkg::DIG_CNT_W-1:0]  job_cnt_o
);
  import adfp_pkg::*;

  adfp_phase_e           phase_q, phase_d;
  logic                  neg_q, neg_d;
  logic [INT_BITS-1:0]   int_q, int_d;
  logic                  sat_q, sat_d;
  logic [FRAC_ACC_W-1:0] frac_q, frac_d;
  logic [DIG_CNT_W-1:0]  cnt_q, cnt_d;

  logic                  job_valid_q;
  logic [INT_BITS-1:0]   job_int_q;
  adfp_flags_t           job_flags_q;
  logic [FRAC_ACC_W-1:0] job_rem_q;
  logic [DIG_CNT_W-1:0]  job_cnt_q;

  logic                  accept;
  logic                  is_digit;
  logic [3:0]            digit;
  logic                  as_int;
  logic                  as_frac;
  logic                  emit;
  logic [INT_BITS+3:0]   int_next;
  logic [FRAC_ACC_W+3:0] frac_next;

  // A new character is taken whenever the job register is free or draining.
  assign char_ready_o = !job_valid_q || job_ready_i;
  assign accept       = char_valid_i && char_ready_o;

  assign is_digit = char_i inside {[CH_ZERO:CH_NINE]};
  assign digit    = char_i[3:0];

  // Times ten as two shifts plus the new digit.
  assign int_next  = ({4'b0, int_q} << 3) + ({4'b0, int_q} << 1)
                   + {{INT_BITS{1'b0}}, digit};
  assign frac_next = ({4'b0, frac_q} << 3) + ({4'b0, frac_q} << 1)
                   + {{FRAC_ACC_W{1'b0}}, digit};

  // Next-state logic of the parser.
  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    int_d   = int_q;
    sat_d   = sat_q;
    frac_d  = frac_q;
    cnt_d   = cnt_q;
    as_int  = 1'b0;
    as_frac = 1'b0;
    emit    = 1'b0;
    if (accept) begin
      case (phase_q)
        PH_INT:  as_int = 1'b1;
        PH_FRAC: as_frac = 1'b1;
        default: begin
          // Start of a number: a sign is consumed, anything else is read as
          // the first character of the integer part.
          phase_d = PH_INT;
          if (char_i == CH_MINUS) begin
            neg_d = 1'b1;
          end else if (char_i != CH_PLUS) begin
            as_int = 1'b1;
          end
        end
      endcase

      if (as_int) begin
        if (is_digit) begin
          if (!sat_q) begin
            if (int_next[INT_BITS+3:INT_BITS] != 4'd0) begin
              int_d = '1;
              sat_d = 1'b1;
            end else begin
              int_d = int_next[INT_BITS-1:0];
            end
          end
        end else if (char_i == CH_POINT) begin
          phase_d = PH_FRAC;
        end else begin
          emit = 1'b1;
        end
      end

      if (as_frac) begin
        if (is_digit) begin
          if (cnt_q < DIG_CNT_W'(MAX_FRAC_DIGITS)) begin
            frac_d = frac_next[FRAC_ACC_W-1:0];
            cnt_d  = cnt_q + 1'b1;
          end
        end else begin
          emit = 1'b1;
        end
      end

      // The terminator hands the number on and clears everything.
      if (emit) begin
        phase_d = PH_START;
        neg_d   = 1'b0;
        int_d   = '0;
        sat_d   = 1'b0;
        frac_d  = '0;
        cnt_d   = '0;
      end
    end
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      neg_q   <= 1'b0;
      int_q   <= '0;
      sat_q   <= 1'b0;
      frac_q  <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      int_q   <= int_d;
      sat_q   <= sat_d;
      frac_q  <= frac_d;
      cnt_q   <= cnt_d;
    end
  end

  // Job handshake towards the divider.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
    end else if (char_ready_o) begin
      job_valid_q <= accept && emit;
    end
  end

  // Job payload, captured from the state before it is cleared.
  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      job_int_q       <= int_q;
      job_flags_q.neg <= neg_q;
      job_flags_q.sat <= sat_q;
      job_rem_q       <= frac_q;
      job_cnt_q       <= cnt_q;
    end
  end

  assign job_valid_o = job_valid_q;
  assign job_int_o   = job_int_q;
  assign job_flags_o = job_flags_q;
  assign job_rem_o   = job_rem_q;
  assign job_cnt_o   = job_cnt_q;

endmodule

### rtl/core/adfp_div_stage.sv
// Fraction scaler: turns the fraction digits into binary fraction bits by a
// reciprocal multiply and one correction step over two pipeline registers.
// Depends on adfp_pkg.
`timescale 1ns / 1ps

module adfp_div_stage #(
  parameter int INT_BITS  = 31,
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  logic [INT_BITS-1:0]             int_i,
  input  adfp_pkg::adfp_flags_t           flags_i,
  input  logic [adfp_pkg::FRAC_ACC_W-1:0] rem_i,
  input  logic [adfp_pkg::DIG_CNT_W-1:0]  cnt_i,
  output logic                            valid_o,
  input  logic                            ready_i,
  output logic [INT_BITS-1:0]             int_o,
  output adfp_pkg::adfp_flags_t           flags_o,
  output logic [FRAC_BITS-1:0]            quo_o
);
  import adfp_pkg::*;

  localparam int RECIP_W = FRAC_BITS + 1;
  localparam int PROD_W  = FRAC_ACC_W + RECIP_W;
  localparam int WIDE_W  = FRAC_ACC_W + FRAC_BITS;

  // Reciprocal floor(2^(FRAC_BITS+k) / 10^n), with k from adfp_pow10_shift.
  // The fraction is below 10^n, so the estimate falls short by at most one.
  function automatic logic [RECIP_W-1:0] recip(input logic [DIG_CNT_W-1:0] n);
    logic [RECIP_W-1:0] r;
    case (n)
      4'd0:    r = RECIP_W'((64'd1 << FRAC_BITS) / 64'd1);
      4'd1:    r = RECIP_W'((64'd1 << (FRAC_BITS + 4)) / 64'd10);
      4'd2:    r = RECIP_W'((64'd1 << (FRAC_BITS + 7)) / 64'd100);
      4'd3:    r = RECIP_W'((64'd1 << (FRAC_BITS + 10)) / 64'd1000);
      4'd4:    r = RECIP_W'((64'd1 << (FRAC_BITS + 14)) / 64'd10000);
      4'd5:    r = RECIP_W'((64'd1 << (FRAC_BITS + 17)) / 64'd100000);
      4'd6:    r = RECIP_W'((64'd1 << (FRAC_BITS + 20)) / 64'd1000000);
      4'd7:    r = RECIP_W'((64'd1 << (FRAC_BITS + 24)) / 64'd10000000);
      4'd8:    r = RECIP_W'((64'd1 << (FRAC_BITS + 27)) / 64'd100000000);
      4'd9:    r = RECIP_W'((64'd1 << (FRAC_BITS + 30)) / 64'd1000000000);
      default: r = RECIP_W'((64'd1 << (FRAC_BITS + 30)) / 64'd1000000000);
    endcase
    return r;
  endfunction

  logic                  a_valid_q;
  logic [INT_BITS-1:0]   a_int_q;
  adfp_flags_t           a_flags_q;
  logic [FRAC_ACC_W-1:0] a_rem_q;
  logic [DIG_CNT_W-1:0]  a_cnt_q;
  logic [FRAC_BITS-1:0]  a_quo_q;

  logic                  b_valid_q;
  logic [INT_BITS-1:0]   b_int_q;
  adfp_flags_t           b_flags_q;
  logic [FRAC_BITS-1:0]  b_quo_q;

  logic                  a_ready;
  logic                  b_ready;
  logic [RECIP_W-1:0]    recip_a;
  logic [4:0]            shift_a;
  logic [PROD_W-1:0]     prod_a;
  logic [PROD_W-1:0]     scaled_a;
  logic [FRAC_ACC_W-1:0] div_b;
  logic [WIDE_W-1:0]     target_b;
  logic [WIDE_W-1:0]     back_b;
  logic [WIDE_W-1:0]     resid_b;
  logic                  bump_b;

  assign b_ready = !b_valid_q || ready_i;
  assign a_ready = !a_valid_q || b_ready;
  assign ready_o = a_ready;

  // First step: quotient estimate from the reciprocal.
  assign recip_a  = recip(cnt_i);
  assign shift_a  = adfp_pow10_shift(cnt_i);
  assign prod_a   = {{RECIP_W{1'b0}}, rem_i} * {{FRAC_ACC_W{1'b0}}, recip_a};
  assign scaled_a = prod_a >> shift_a;

  // Second step: add one where the remainder still covers the divisor.
  assign div_b    = adfp_pow10(a_cnt_q);
  assign target_b = {a_rem_q, {FRAC_BITS{1'b0}}};
  assign back_b   = {{FRAC_ACC_W{1'b0}}, a_quo_q} * {{FRAC_BITS{1'b0}}, div_b};
  assign resid_b  = target_b - back_b;
  assign bump_b   = resid_b >= {{FRAC_BITS{1'b0}}, div_b};

  // Valid bits of both steps.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= valid_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  // Payload of the estimate step.
  always_ff @(posedge clk_i) begin
    if (a_ready && valid_i) begin
      a_int_q   <= int_i;
      a_flags_q <= flags_i;
      a_rem_q   <= rem_i;
      a_cnt_q   <= cnt_i;
      a_quo_q   <= scaled_a[FRAC_BITS-1:0];
    end
  end

  // Payload of the correction step.
  always_ff @(posedge clk_i) begin
    if (b_ready && a_valid_q) begin
      b_int_q   <= a_int_q;
      b_flags_q <= a_flags_q;
      b_quo_q   <= a_quo_q + {{(FRAC_BITS-1){1'b0}}, bump_b};
    end
  end

  assign valid_o = b_valid_q;
  assign int_o   = b_int_q;
  assign flags_o = b_flags_q;
  assign quo_o   = b_quo_q;

endmodule

### rtl/core/ascii_decimal_to_fixed_point.sv
// ASCII decimal to Q(INT_BITS).(FRAC_BITS) converter, one character per word.
// A result goes through the job, estimate, correction and output registers in turn.
// One word per cycle unless stalled; ready runs back through every register.
// Reset clears parser state and all valid bits; the first word is taken at once.
// Depends on adfp_pkg, adfp_parser, adfp_div_stage and the assertion header.
`timescale 1ns / 1ps

`include "ascii_decimal_to_fixed_point_assert.svh"

module ascii_decimal_to_fixed_point #(
  parameter int INT_BITS        = 31,
  parameter int FRAC_BITS       = 16,
  parameter int MAX_FRAC_DIGITS = 9,
  localparam int VALUE_W        = 1 + INT_BITS + FRAC_BITS,
  localparam int OUT_DATA_W     = ((VALUE_W + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,  // [7:0] char_in
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // [VALUE_W-1:0] value, rest zero
  output logic [0:0]            m_axis_tuser   // [0] overflow
);
  import adfp_pkg::*;

  localparam logic [VALUE_W-1:0] MOST_NEG = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic [VALUE_W-1:0] MAG_MAX  = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] NEG_MAX  = VALUE_W'(0) - MAG_MAX;

  logic                  job_valid;
  logic                  job_ready;
  logic [INT_BITS-1:0]   job_int;
  adfp_flags_t           job_flags;
  logic [FRAC_ACC_W-1:0] job_rem;
  logic [DIG_CNT_W-1:0]  job_cnt;

  logic                  frac_valid;
  logic [INT_BITS-1:0]   frac_int;
  adfp_flags_t           frac_flags;
  logic [FRAC_BITS-1:0]  frac_quo;

  logic                       out_valid_q;
  logic [VALUE_W-1:0]         value_q;
  logic                       ovf_q;
  logic                       out_ready;
  logic [INT_BITS+FRAC_BITS-1:0] mag;
  logic [VALUE_W-1:0]         value_d;

  // Character parser and job register.
  adfp_parser #(
    .INT_BITS        (INT_BITS),
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .char_valid_i (s_axis_tvalid),
    .char_i       (s_axis_tdata),
    .char_ready_o (s_axis_tready),
    .job_ready_i  (job_ready),
    .job_valid_o  (job_valid),
    .job_int_o    (job_int),
    .job_flags_o  (job_flags),
    .job_rem_o    (job_rem),
    .job_cnt_o    (job_cnt)
  );

  // Fraction scaler: decimal fraction digits to binary fraction bits.
  adfp_div_stage #(
    .INT_BITS  (INT_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_frac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (job_valid),
    .ready_o (job_ready),
    .int_i   (job_int),
    .flags_i (job_flags),
    .rem_i   (job_rem),
    .cnt_i   (job_cnt),
    .valid_o (frac_valid),
    .ready_i (out_ready),
    .int_o   (frac_int),
    .flags_o (frac_flags),
    .quo_o   (frac_quo)
  );

  // The fraction is below one, so integer and fraction bits simply join.
  assign mag = frac_flags.sat ? '1 : {frac_int, frac_quo};
  assign value_d = frac_flags.neg ? (VALUE_W'(0) - {1'b0, mag}) : {1'b0, mag};

  assign out_ready = !out_valid_q || m_axis_tready;

  // Output register valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= frac_valid;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (out_ready && frac_valid) begin
      value_q <= value_d;
      ovf_q   <= frac_flags.sat;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = OUT_DATA_W'(value_q);
  assign m_axis_tuser[0] = ovf_q;

  // An empty output register leaves the whole chain ready for input.
  `ADFP_ASSERT_IMPLY(a_ready_when_empty, clk_i, rst_ni, !out_valid_q, s_axis_tready)
  // A saturated result carries the largest magnitude with its sign.
  `ADFP_ASSERT_IMPLY(a_ovf_value, clk_i, rst_ni, out_valid_q && ovf_q,
    (value_q == MAG_MAX) || (value_q == NEG_MAX))
  // The magnitude never reaches the most negative code.
  `ADFP_ASSERT_NEVER(a_no_most_neg, clk_i, rst_ni, out_valid_q && (value_q == MOST_NEG))

endmodule
